// ===== rtl/core/linear_regression_gradient_descent_top_assert.svh =====
// assertion macros for the line fit block
// used by the top level; expects clk and rst_n in scope
`ifndef LINEAR_REGRESSION_GRADIENT_DESCENT_TOP_ASSERT_SVH
`define LINEAR_REGRESSION_GRADIENT_DESCENT_TOP_ASSERT_SVH

// same-cycle implication
`define LRGD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LRGD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/lrgd_pkg.sv =====
// shared constants and types for the line fit block
// no dependencies
package lrgd_pkg;

  localparam int MAX_SAMPLES = 1024;
  localparam int ADDR_W      = $clog2(MAX_SAMPLES);
  localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
  localparam int DIV_W       = 64;
  localparam int DIV_CNT_W   = $clog2(DIV_W + 1);
  localparam int CFG_IDX_W   = 3;

  localparam logic [31:0] RST_PRICE_MIN  = 32'd939272602;
  localparam logic [31:0] RST_RANGE_RECIP = 32'd17272;
  localparam logic [31:0] RST_RATE       = 32'd858993;
  localparam logic [15:0] RST_EPOCHS     = 16'd1000;
  localparam logic [31:0] RST_INIT_ICPT  = 32'd1677722;
  localparam logic [31:0] RST_INIT_SLOPE = 32'd1677722;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PRICE_MIN   = 3'd0,
    CFG_RANGE_RECIP = 3'd1,
    CFG_RATE        = 3'd2,
    CFG_EPOCHS      = 3'd3,
    CFG_INIT_ICPT   = 3'd4,
    CFG_INIT_SLOPE  = 3'd5
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_LOAD,
    S_DRAIN,
    S_EPOCH,
    S_SCAN,
    S_FLUSH,
    S_DIV_GO,
    S_DIV_WAIT,
    S_MUL_HI,
    S_MUL_LO,
    S_APPLY,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    SEL_ICPT,
    SEL_SLOPE,
    SEL_MSE
  } sel_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== rtl/core/lrgd_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
module lrgd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/lrgd_div.sv =====
// bit-serial unsigned divider, 64-bit dividend by sample count
// depends on lrgd_pkg
module lrgd_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [lrgd_pkg::DIV_W-1:0]    dividend,
  input  logic [lrgd_pkg::CNT_W-1:0]    divisor,
  output logic [lrgd_pkg::DIV_W-1:0]    quotient,
  output lrgd_pkg::div_stat_t           stat
);

  logic [lrgd_pkg::CNT_W-1:0]     rem_r;
  logic [lrgd_pkg::DIV_W-1:0]     quo_r;
  logic [lrgd_pkg::CNT_W-1:0]     dvs_r;
  logic [lrgd_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                           busy_r;
  logic                           done_r;
  logic [lrgd_pkg::CNT_W:0]       trial;
  logic                           fits;

  assign trial = {rem_r, quo_r[lrgd_pkg::DIV_W-1]};
  assign fits  = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= lrgd_pkg::DIV_CNT_W'(lrgd_pkg::DIV_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - lrgd_pkg::DIV_CNT_W'(1);
        if (cnt_r == lrgd_pkg::DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[lrgd_pkg::DIV_W-2:0], fits};
      rem_r <= fits ? lrgd_pkg::CNT_W'(trial - {1'b0, dvs_r})
                    : trial[lrgd_pkg::CNT_W-1:0];
    end
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// ===== rtl/core/linear_regression_gradient_descent_top.sv =====
// Line fit by batch gradient descent over a stored price series. Samples are
// taken one per cycle, normalized in a two-stage pipeline and written to a
// 1024-entry sample ram; the item marked last starts the fit. Each epoch
// streams the n stored samples through a pipelined error/accumulate path at
// one sample a cycle, then divides the three sums by n on a shared
// bit-serial divider and applies two coefficient steps. Inputs stall during
// the fit. The result waits in an output register, and the next series
// loads while it does. The sample ram needs no clearing pass after reset.
// depends on lrgd_pkg, lrgd_ram, lrgd_div and the assertion header
`include "linear_regression_gradient_descent_top_assert.svh"

module linear_regression_gradient_descent_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [31:0]                      in_open_price,
  input  logic                             in_last_sample,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [31:0]               out_intercept,
  output logic signed [31:0]               out_slope,
  output logic [31:0]                      out_mean_square_error,
  output logic [10:0]                      out_samples_used,
  output logic                             out_overflowed,
  input  logic                             cfg_wr_en,
  input  logic [lrgd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]                      cfg_wr_data
);

  localparam int AW      = lrgd_pkg::ADDR_W;
  localparam int CW      = lrgd_pkg::CNT_W;
  localparam int SPROD_W = 32 + AW + 1;
  localparam int ERR_W   = SPROD_W + 2;

  function automatic logic [31:0] norm_sat(input logic neg, input logic [47:0] q);
    logic [31:0] r;
    if (!neg) begin
      r = (q > 48'h7FFFFFFF) ? 32'h7FFFFFFF : q[31:0];
    end else begin
      r = (q > 48'h80000000) ? 32'h80000000 : (32'h0 - q[31:0]);
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat_err(input logic signed [ERR_W-1:0] v);
    logic signed [31:0] r;
    if (v > $signed(ERR_W'(32'sh7FFFFFFF))) begin
      r = 32'sh7FFFFFFF;
    end else if (v < $signed(ERR_W'(-64'sh80000000))) begin
      r = -32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat_coef(input logic signed [51:0] v);
    logic signed [31:0] r;
    if (v > 52'sh7FFFFFFF) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -52'sh80000000) begin
      r = -32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

  // configuration
  logic [31:0]        price_min_r;
  logic [31:0]        range_recip_r;
  logic [31:0]        rate_r;
  logic [15:0]        epochs_r;
  logic [31:0]        init_icpt_r;
  logic [31:0]        init_slope_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      price_min_r   <= lrgd_pkg::RST_PRICE_MIN;
      range_recip_r <= lrgd_pkg::RST_RANGE_RECIP;
      rate_r        <= lrgd_pkg::RST_RATE;
      epochs_r      <= lrgd_pkg::RST_EPOCHS;
      init_icpt_r   <= lrgd_pkg::RST_INIT_ICPT;
      init_slope_r  <= lrgd_pkg::RST_INIT_SLOPE;
    end else if (cfg_wr_en) begin
      unique case (lrgd_pkg::cfg_idx_t'(cfg_index))
        lrgd_pkg::CFG_PRICE_MIN:   price_min_r   <= cfg_wr_data;
        lrgd_pkg::CFG_RANGE_RECIP: range_recip_r <= cfg_wr_data;
        lrgd_pkg::CFG_RATE:        rate_r        <= cfg_wr_data;
        lrgd_pkg::CFG_EPOCHS:      epochs_r      <= cfg_wr_data[15:0];
        lrgd_pkg::CFG_INIT_ICPT:   init_icpt_r   <= cfg_wr_data;
        lrgd_pkg::CFG_INIT_SLOPE:  init_slope_r  <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  lrgd_pkg::state_t state_r, state_nxt;
  lrgd_pkg::sel_t   sel_r;

  logic               in_accept;
  logic               ram_re;
  logic               div_start;
  logic               out_load;
  logic [CW-1:0]      count_r;
  logic               ovf_r;
  logic               store_ok;

  // load pipeline
  logic               s1_vld_r, s2_vld_r;
  logic               s1_neg_r, s2_neg_r;
  logic [31:0]        s1_mag_r;
  logic [AW-1:0]      s1_addr_r, s2_addr_r;
  logic [63:0]        s2_prod_r;
  logic [31:0]        ram_wdata;

  // scan pipeline
  logic [CW-1:0]            scan_i_r;
  logic [AW-1:0]            scan_addr;
  logic                     scan_last;
  logic [31:0]              ram_rdata;
  logic                     p1_vld_r, p2_vld_r, p3_vld_r;
  logic [AW-1:0]            p1_idx_r, p2_idx_r;
  logic signed [SPROD_W-1:0] p1_sprod_r, p3_wprod_r;
  logic signed [ERR_W-1:0]  err_wide;
  logic signed [31:0]       p2_err_r, p3_err_r;
  logic signed [63:0]       p3_sq_r;
  logic signed [63:0]       esum_r, wsum_r;
  logic [63:0]              ssum_r;
  logic                     pipe_busy;

  // coefficients and update
  logic signed [31:0]  icpt_r, slope_r;
  logic [15:0]         epoch_ctr_r;
  logic [31:0]         mse_r;
  logic                div_neg_r;
  logic [63:0]         div_dividend;
  logic [63:0]         div_quo;
  lrgd_pkg::div_stat_t div_stat;
  logic [55:0]         hi_r, lo_r;
  logic [56:0]         low_sum;
  logic [49:0]         step;
  logic signed [31:0]  coef_sel;
  logic signed [51:0]  coef_wide;

  assign in_accept = in_valid && !in_stall;
  assign store_ok  = count_r < CW'(lrgd_pkg::MAX_SAMPLES);
  assign scan_addr = scan_i_r[AW-1:0];
  assign scan_last = scan_i_r == (count_r - CW'(1));
  assign pipe_busy = p1_vld_r || p2_vld_r || p3_vld_r;
  assign out_load  = (state_r == lrgd_pkg::S_DONE) && (!out_valid || !out_stall);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lrgd_pkg::S_LOAD:     if (in_accept && in_last_sample) state_nxt = lrgd_pkg::S_DRAIN;
      lrgd_pkg::S_DRAIN:    if (!s1_vld_r && !s2_vld_r) state_nxt = lrgd_pkg::S_EPOCH;
      lrgd_pkg::S_EPOCH: begin
        state_nxt = (epoch_ctr_r == epochs_r) ? lrgd_pkg::S_DONE : lrgd_pkg::S_SCAN;
      end
      lrgd_pkg::S_SCAN:     if (scan_last) state_nxt = lrgd_pkg::S_FLUSH;
      lrgd_pkg::S_FLUSH:    if (!pipe_busy) state_nxt = lrgd_pkg::S_DIV_GO;
      lrgd_pkg::S_DIV_GO:   state_nxt = lrgd_pkg::S_DIV_WAIT;
      lrgd_pkg::S_DIV_WAIT: begin
        if (div_stat.done) begin
          state_nxt = (sel_r == lrgd_pkg::SEL_MSE) ? lrgd_pkg::S_EPOCH : lrgd_pkg::S_MUL_HI;
        end
      end
      lrgd_pkg::S_MUL_HI:   state_nxt = lrgd_pkg::S_MUL_LO;
      lrgd_pkg::S_MUL_LO:   state_nxt = lrgd_pkg::S_APPLY;
      lrgd_pkg::S_APPLY:    state_nxt = lrgd_pkg::S_DIV_GO;
      lrgd_pkg::S_DONE:     if (out_load) state_nxt = lrgd_pkg::S_LOAD;
      default:              state_nxt = lrgd_pkg::S_LOAD;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall  = 1'b1;
    ram_re    = 1'b0;
    div_start = 1'b0;
    unique case (state_r)
      lrgd_pkg::S_LOAD:   in_stall  = 1'b0;
      lrgd_pkg::S_SCAN:   ram_re    = 1'b1;
      lrgd_pkg::S_DIV_GO: div_start = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lrgd_pkg::S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  // sample count, overflow, output valid and pipeline valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      ovf_r     <= 1'b0;
      out_valid <= 1'b0;
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      p1_vld_r  <= 1'b0;
      p2_vld_r  <= 1'b0;
      p3_vld_r  <= 1'b0;
    end else begin
      if (out_load) begin
        count_r <= '0;
        ovf_r   <= 1'b0;
      end else if (in_accept) begin
        if (store_ok) begin
          count_r <= count_r + CW'(1);
        end else begin
          ovf_r <= 1'b1;
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      s1_vld_r <= in_accept && store_ok;
      s2_vld_r <= s1_vld_r;
      p1_vld_r <= ram_re;
      p2_vld_r <= p1_vld_r;
      p3_vld_r <= p2_vld_r;
    end
  end

  // normalization pipeline
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_neg_r  <= in_open_price < price_min_r;
      s1_mag_r  <= (in_open_price < price_min_r) ? (price_min_r - in_open_price)
                                                 : (in_open_price - price_min_r);
      s1_addr_r <= count_r[AW-1:0];
    end
    s2_prod_r <= 64'(s1_mag_r) * 64'(range_recip_r);
    s2_neg_r  <= s1_neg_r;
    s2_addr_r <= s1_addr_r;
  end

  assign ram_wdata = norm_sat(s2_neg_r, s2_prod_r[63:16]);

  lrgd_ram #(
    .WIDTH (32),
    .DEPTH (lrgd_pkg::MAX_SAMPLES)
  ) u_store (
    .clk   (clk),
    .we    (s2_vld_r),
    .waddr (s2_addr_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (scan_addr),
    .rdata (ram_rdata)
  );

  // error and accumulate pipeline
  assign err_wide = ERR_W'(icpt_r) + ERR_W'(p1_sprod_r) - ERR_W'($signed(ram_rdata));

  always_ff @(posedge clk) begin
    p1_idx_r   <= scan_addr;
    p1_sprod_r <= $signed(slope_r) * $signed({1'b0, scan_addr});
    p2_err_r   <= sat_err(err_wide);
    p2_idx_r   <= p1_idx_r;
    p3_err_r   <= p2_err_r;
    p3_wprod_r <= p2_err_r * $signed({1'b0, p2_idx_r});
    p3_sq_r    <= p2_err_r * p2_err_r;
    if (state_r == lrgd_pkg::S_EPOCH) begin
      esum_r   <= '0;
      wsum_r   <= '0;
      ssum_r   <= '0;
      scan_i_r <= '0;
    end else begin
      if (ram_re) begin
        scan_i_r <= scan_i_r + CW'(1);
      end
      if (p3_vld_r) begin
        esum_r <= esum_r + 64'(p3_err_r);
        wsum_r <= wsum_r + 64'(p3_wprod_r);
        ssum_r <= ssum_r + {24'd0, p3_sq_r[63:24]};
      end
    end
  end

  // update path
  always_comb begin
    unique case (sel_r)
      lrgd_pkg::SEL_ICPT:  div_dividend = mag64(esum_r);
      lrgd_pkg::SEL_SLOPE: div_dividend = mag64(wsum_r);
      default:             div_dividend = ssum_r;
    endcase
  end

  lrgd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (count_r),
    .quotient (div_quo),
    .stat     (div_stat)
  );

  assign low_sum   = {26'd0, hi_r[6:0], 24'd0} + {1'b0, lo_r};
  assign step      = 50'(hi_r[55:7]) + 50'(low_sum[56:31]);
  assign coef_sel  = (sel_r == lrgd_pkg::SEL_ICPT) ? icpt_r : slope_r;
  assign coef_wide = div_neg_r ? (52'(coef_sel) + $signed({2'b00, step}))
                               : (52'(coef_sel) - $signed({2'b00, step}));

  always_ff @(posedge clk) begin
    unique case (state_r)
      lrgd_pkg::S_LOAD: begin
        if (in_accept && in_last_sample) begin
          icpt_r      <= init_icpt_r;
          slope_r     <= init_slope_r;
          epoch_ctr_r <= '0;
          mse_r       <= '0;
        end
      end
      lrgd_pkg::S_FLUSH: sel_r <= lrgd_pkg::SEL_ICPT;
      lrgd_pkg::S_DIV_GO: begin
        div_neg_r <= (sel_r == lrgd_pkg::SEL_ICPT) ? esum_r[63] : wsum_r[63];
      end
      lrgd_pkg::S_DIV_WAIT: begin
        if (div_stat.done && sel_r == lrgd_pkg::SEL_MSE) begin
          mse_r       <= (div_quo[63:32] != 32'd0) ? 32'hFFFFFFFF : div_quo[31:0];
          epoch_ctr_r <= epoch_ctr_r + 16'd1;
        end
      end
      lrgd_pkg::S_MUL_HI: hi_r <= 56'(rate_r) * 56'(div_quo[47:24]);
      lrgd_pkg::S_MUL_LO: lo_r <= 56'(rate_r) * 56'(div_quo[23:0]);
      lrgd_pkg::S_APPLY: begin
        if (sel_r == lrgd_pkg::SEL_ICPT) begin
          icpt_r <= sat_coef(coef_wide);
          sel_r  <= lrgd_pkg::SEL_SLOPE;
        end else begin
          slope_r <= sat_coef(coef_wide);
          sel_r   <= lrgd_pkg::SEL_MSE;
        end
      end
      default: ;
    endcase
    if (out_load) begin
      out_intercept         <= icpt_r;
      out_slope             <= slope_r;
      out_mean_square_error <= mse_r;
      out_samples_used      <= 11'(count_r);
      out_overflowed        <= ovf_r;
    end
  end

  `LRGD_ASSERT_IMP(a_count_bound, 1'b1, count_r <= CW'(lrgd_pkg::MAX_SAMPLES), "sample count beyond store")
  `LRGD_ASSERT_IMP(a_div_after_flush, state_r == lrgd_pkg::S_DIV_GO, !pipe_busy && !s2_vld_r, "divide with sums pending")
  `LRGD_ASSERT_IMP(a_div_idle_start, div_start, !div_stat.busy, "divider restarted while busy")
  `LRGD_ASSERT_NXT(a_result_shown, out_load, out_valid, "finished fit not presented")

endmodule

// ===== tb/sv/tb_linear_regression_gradient_descent_top.sv =====
// testbench for the gradient-descent line fit block: loads price series, checks each
// fit result against a built-in fixed-point predictor of the epoch loop
// depends on lrgd_pkg and linear_regression_gradient_descent_top
module tb_linear_regression_gradient_descent_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 1000000;
  localparam int ITEM_TARGET = 1850;

  typedef struct {
    logic signed [31:0] intercept;
    logic signed [31:0] slope;
    logic [31:0]        mse;
    logic [10:0]        used;
    logic               ovf;
  } fit_t;

  logic clk, rst_n;
  logic in_valid, in_stall, in_last_sample;
  logic [31:0] in_open_price;
  logic out_valid, out_stall, out_overflowed;
  logic signed [31:0] out_intercept, out_slope;
  logic [31:0] out_mean_square_error;
  logic [10:0] out_samples_used;
  logic cfg_wr_en;
  logic [lrgd_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [31:0] cfg_wr_data;

  linear_regression_gradient_descent_top uut (.*);

  // shadow of the block's registers and sample store
  logic [31:0] sh_pmin, sh_recip, sh_rate, sh_icpt, sh_slope;
  logic [15:0] sh_epochs;
  logic [31:0] norm_store [lrgd_pkg::MAX_SAMPLES];
  int held_count;
  bit held_ovf;

  fit_t fit_q[$];
  int err_count, items_sent, fits_seen, idle_cycles;
  bit quiet;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  function automatic longint sat32(longint v);
    if (v > 64'sh7FFFFFFF) return 64'sh7FFFFFFF;
    if (v < -64'sh80000000) return -64'sh80000000;
    return v;
  endfunction

  function automatic logic [31:0] normalize_price(logic [31:0] p);
    longint diff, s;
    longint unsigned m, q;
    diff = longint'(p) - longint'(sh_pmin);
    m = (diff < 0) ? -diff : diff;
    q = (m * longint'(sh_recip)) >> 16;
    s = longint'(q);
    return 32'(sat32(diff < 0 ? -s : s));
  endfunction

  function automatic longint descend_coef(longint coef, longint sum, longint n);
    longint mean, step;
    logic [127:0] prod;
    mean = sum / n;
    prod = 128'(sh_rate) * 128'(mean < 0 ? -mean : mean);
    step = longint'(prod >> 31);
    return sat32(mean < 0 ? coef + step : coef - step);
  endfunction

  function automatic fit_t predict_fit();
    fit_t r;
    longint n, b0, b1, esum, wsum, err, i;
    longint unsigned ssum, mse;
    n = held_count;
    b0 = longint'($signed(sh_icpt));
    b1 = longint'($signed(sh_slope));
    mse = 0;
    for (int e = 0; e < sh_epochs; e++) begin
      esum = 0; wsum = 0; ssum = 0;
      for (i = 0; i < n; i++) begin
        err = sat32(b0 + b1 * i - longint'($signed(norm_store[i])));
        esum += err;
        wsum += err * i;
        ssum += longint'(err * err) >> 24;
      end
      b0 = descend_coef(b0, esum, n);
      b1 = descend_coef(b1, wsum, n);
      mse = ssum / longint'(n);
    end
    r.intercept = 32'(b0);
    r.slope = 32'(b1);
    r.mse = (mse > 64'hFFFFFFFF) ? 32'hFFFFFFFF : 32'(mse);
    r.used = 11'(held_count);
    r.ovf = held_ovf;
    return r;
  endfunction

  task automatic send_price(input logic [31:0] p, input bit last);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_open_price <= p;
    in_last_sample <= last;
    do @(posedge clk); while (in_stall);
    if (held_count < lrgd_pkg::MAX_SAMPLES) begin
      norm_store[held_count] = normalize_price(p);
      held_count++;
    end else begin
      held_ovf = 1'b1;
    end
    if (last) begin
      fit_q.push_back(predict_fit());
      held_count = 0;
      held_ovf = 1'b0;
    end
    items_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(input lrgd_pkg::cfg_idx_t idx, input logic [31:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wr_data <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
    case (idx)
      lrgd_pkg::CFG_PRICE_MIN:   sh_pmin = val;
      lrgd_pkg::CFG_RANGE_RECIP: sh_recip = val;
      lrgd_pkg::CFG_RATE:        sh_rate = val;
      lrgd_pkg::CFG_EPOCHS:      sh_epochs = val[15:0];
      lrgd_pkg::CFG_INIT_ICPT:   sh_icpt = val;
      lrgd_pkg::CFG_INIT_SLOPE:  sh_slope = val;
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (fit_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_series(input int n, input logic [31:0] base, input int spread);
    for (int k = 0; k < n; k++)
      send_price(($urandom_range(0, 9) == 0) ? $urandom() : base + $urandom_range(0, spread),
                 k == n - 1);
  endtask

  task automatic set_all(input logic [31:0] pmin, recip, rate, input logic [15:0] ep,
                         input logic [31:0] icpt, slope);
    write_reg(lrgd_pkg::CFG_PRICE_MIN, pmin);
    write_reg(lrgd_pkg::CFG_RANGE_RECIP, recip);
    write_reg(lrgd_pkg::CFG_RATE, rate);
    write_reg(lrgd_pkg::CFG_EPOCHS, {16'h0, ep});
    write_reg(lrgd_pkg::CFG_INIT_ICPT, icpt);
    write_reg(lrgd_pkg::CFG_INIT_SLOPE, slope);
  endtask

  // reset values, one short series
  task automatic test_reset_config();
    send_series(3, lrgd_pkg::RST_PRICE_MIN, 32'h0010_0000);
    wait_idle();
  endtask

  task automatic test_field_extremes();
    set_all(32'h0, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'd2, 32'h7FFFFFFF, 32'h80000000);
    send_price(32'h0, 1'b0);
    send_price(32'hFFFFFFFF, 1'b0);
    send_price(32'h8000_0000, 1'b1);
    wait_idle();
    set_all(32'hFFFFFFFF, 32'h0, 32'h0, 16'd1, 32'h80000000, 32'h7FFFFFFF);
    send_price(32'h0, 1'b0);
    send_price(32'hFFFFFFFF, 1'b1);
    wait_idle();
    set_all(32'h8000_0000, 32'h0100_0000, 32'h4000_0000, 16'd3, 32'h0, 32'h0);
    send_price(32'h7FFF_FFFF, 1'b0);
    send_price(32'h8000_0001, 1'b0);
    send_price(32'h5555_5555, 1'b0);
    send_price(32'hAAAA_AAAA, 1'b1);
    send_price(32'h8000_0000, 1'b1);
    wait_idle();
  endtask

  task automatic test_zero_epochs();
    write_reg(lrgd_pkg::CFG_EPOCHS, 32'h0000_FFFF);
    write_reg(lrgd_pkg::CFG_EPOCHS, 32'h0);
    send_series(4, 32'h1000_0000, 32'h00FF_FFFF);
    wait_idle();
  endtask

  // store fills, further samples are dropped including the last
  task automatic test_full_store();
    set_all(32'h3000_0000, 32'h0000_4000, 32'h0010_0000, 16'd1, 32'h0100_0000, 32'h0);
    send_series(lrgd_pkg::MAX_SAMPLES + 1, 32'h3000_0000, 32'h0FFF_FFFF);
    send_price(32'h3100_0000, 1'b1);
    wait_idle();
  endtask

  task automatic test_random_series();
    logic [31:0] base;
    int n;
    while (items_sent < ITEM_TARGET) begin
      if (items_sent > ITEM_TARGET - 260) quiet = 1'b1;
      if ($urandom_range(0, 3) == 0)
        set_all($urandom_range(0, 3) == 0 ? $urandom() : 32'h3800_0000 + $urandom_range(0, 1 << 24),
                $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(1, 1 << 20),
                $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 1 << 24),
                16'($urandom_range(1, 6)),
                $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 1 << 25),
                $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 1 << 22));
      repeat ($urandom_range(1, 4)) begin
        base = sh_pmin + $urandom_range(0, 1 << 22);
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 160) : $urandom_range(1, 24);
        send_series(n, base, 32'h00FF_FFFF);
      end
      wait_idle();
    end
  endtask

  always @(negedge clk) begin
    if (quiet || $urandom_range(0, 2) != 0) begin
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end else begin
      out_stall <= 1'b1;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
  end

  always @(posedge clk) begin
    fit_t e;
    if (rst_n && out_valid && !out_stall) begin
      fits_seen++;
      if (fit_q.size() == 0) begin
        $error("unexpected fit result");
        err_count++;
      end else begin
        e = fit_q.pop_front();
        if (out_intercept !== e.intercept) begin
          $error("intercept exp %h got %h", e.intercept, out_intercept); err_count++;
        end
        if (out_slope !== e.slope) begin
          $error("slope exp %h got %h", e.slope, out_slope); err_count++;
        end
        if (out_mean_square_error !== e.mse) begin
          $error("mean_square_error exp %h got %h", e.mse, out_mean_square_error);
          err_count++;
        end
        if (out_samples_used !== e.used) begin
          $error("samples_used exp %0d got %0d", e.used, out_samples_used); err_count++;
        end
        if (out_overflowed !== e.ovf) begin
          $error("overflowed exp %b got %b", e.ovf, out_overflowed); err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_open_price = '0;
    in_last_sample = 1'b0;
    out_stall = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_wr_data = '0;
    quiet = 1'b0;
    err_count = 0; items_sent = 0; fits_seen = 0; idle_cycles = 0;
    held_count = 0; held_ovf = 1'b0;
    sh_pmin = lrgd_pkg::RST_PRICE_MIN; sh_recip = lrgd_pkg::RST_RANGE_RECIP;
    sh_rate = lrgd_pkg::RST_RATE; sh_epochs = lrgd_pkg::RST_EPOCHS;
    sh_icpt = lrgd_pkg::RST_INIT_ICPT; sh_slope = lrgd_pkg::RST_INIT_SLOPE;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_reset_config();
    test_field_extremes();
    test_zero_epochs();
    test_full_store();
    test_random_series();
    wait_idle();
    repeat (50) @(posedge clk);
    $display("sent %0d price items, checked %0d line fits", items_sent, fits_seen);
    $display("covered reset values, register extremes, zero epochs and a full store");
    if (err_count == 0 && fit_q.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
